/* hdl/fvwm_pkg.sv */
package fvwm_pkg;

   // sizes of the stores and the number of voices
   localparam int unsigned WAVE_DEPTH    = 4096;
   localparam int unsigned NOTE_COUNT    = 64;
   localparam int unsigned VOICE_COUNT   = 4;
   localparam int unsigned NOTE_FIELDS   = 4;
   localparam int unsigned ACTIVE_VOICES = (VOICE_COUNT < NOTE_FIELDS) ? VOICE_COUNT : NOTE_FIELDS;

   // field widths of the ports
   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned ADDR_W   = 12;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned OFFSET_W = 12;
   localparam int unsigned PERIOD_W = 12;
   localparam int unsigned NOTE_W   = 6;
   localparam int unsigned SAMPLE_W = 10;

   // derived widths
   localparam int unsigned WADDR_W = $clog2(WAVE_DEPTH);
   localparam int unsigned NIDX_W  = $clog2(NOTE_COUNT);
   localparam int unsigned VIDX_W  = (ACTIVE_VOICES > 1) ? $clog2(ACTIVE_VOICES) : 1;
   localparam int unsigned CMP_W   = (WADDR_W + 1 > PERIOD_W) ? WADDR_W + 1 : PERIOD_W;

   // item function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_WAVE_WR = 2'd0,
      FUNC_NOTE_WR = 2'd1,
      FUNC_TICK    = 2'd2
   } func_type;

   // operation carried into the wave memory stage
   typedef enum logic {
      OP_WAVE_WR = 1'b0,
      OP_VOICE   = 1'b1
   } op_type;

   // one note table entry, offset already folded into the wave memory range
   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [WADDR_W-1:0]  offset;
   } note_entry_type;

   // one wave memory operation from the issue stage
   typedef struct packed {
      logic                valid;
      op_type              op;
      logic [VIDX_W-1:0]   voice;
      logic [NOTE_W-1:0]   note;
      logic                first;
      logic                last;
      logic [WADDR_W-1:0]  wave_addr;
      logic [BYTE_W-1:0]   wave_byte;
   } issue_type;

   // raw 12-bit value modulo the wave memory depth
   function automatic logic [WADDR_W-1:0] wave_index(input logic [ADDR_W-1:0] raw);
      int unsigned v;
      v = 32'(raw);
      for (int k = 3; k >= 0; k--) begin
         if (v >= (WAVE_DEPTH << k)) begin
            v = v - (WAVE_DEPTH << k);
         end
      end
      return WADDR_W'(v);
   endfunction

   // note number modulo the note count
   function automatic logic [NIDX_W-1:0] note_index(input logic [NOTE_W-1:0] raw);
      int unsigned v;
      v = 32'(raw);
      for (int k = NOTE_W - 1; k >= 0; k--) begin
         if (v >= (NOTE_COUNT << k)) begin
            v = v - (NOTE_COUNT << k);
         end
      end
      return NIDX_W'(v);
   endfunction

endpackage

/* hdl/fvwm_note_table.sv */
module fvwm_note_table (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic                          rd_en,
   input  logic [fvwm_pkg::NIDX_W-1:0]   addr,
   input  fvwm_pkg::note_entry_type      wr_data,
   output fvwm_pkg::note_entry_type      rd_data
);

   fvwm_pkg::note_entry_type mem [fvwm_pkg::NOTE_COUNT];
   fvwm_pkg::note_entry_type rd_data_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end else if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/fvwm_wave_ram.sv */
module fvwm_wave_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic                          rd_en,
   input  logic [fvwm_pkg::WADDR_W-1:0]  addr,
   input  logic [fvwm_pkg::BYTE_W-1:0]   wr_data,
   output logic [fvwm_pkg::BYTE_W-1:0]   rd_data
);

   logic [fvwm_pkg::BYTE_W-1:0] mem [fvwm_pkg::WAVE_DEPTH];
   logic [fvwm_pkg::BYTE_W-1:0] rd_data_ff;

   // single port, read data held until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end else if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/fvwm_voice_engine.sv */
module fvwm_voice_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  fvwm_pkg::issue_type           issue,
   input  fvwm_pkg::note_entry_type      entry,
   output logic [fvwm_pkg::WADDR_W-1:0]  wave_addr
);

   localparam int unsigned AW = fvwm_pkg::WADDR_W;
   localparam int unsigned CW = fvwm_pkg::CMP_W;
   localparam logic [AW:0]   DEPTH_A = (AW + 1)'(fvwm_pkg::WAVE_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(fvwm_pkg::WAVE_DEPTH);

   logic [AW-1:0]                  phase_ff     [fvwm_pkg::ACTIVE_VOICES];
   logic [AW-1:0]                  phase_in     [fvwm_pkg::ACTIVE_VOICES];
   logic [fvwm_pkg::NOTE_W-1:0]    last_note_ff [fvwm_pkg::ACTIVE_VOICES];
   logic [fvwm_pkg::NOTE_W-1:0]    last_note_in [fvwm_pkg::ACTIVE_VOICES];

   logic          step;
   logic          restart;
   logic [AW-1:0] cur_phase;
   logic [AW:0]   addr_sum;
   logic [CW-1:0] phase_inc;
   logic [AW-1:0] next_phase;

   assign step = advance && issue.valid && (issue.op == fvwm_pkg::OP_VOICE);

   // current phase, restarting on a note change
   assign restart   = last_note_ff[issue.voice] != issue.note;
   assign cur_phase = restart ? '0 : phase_ff[issue.voice];

   // wave address wraps at the memory depth
   always_comb begin
      addr_sum = {1'b0, entry.offset} + {1'b0, cur_phase};
      if (addr_sum >= DEPTH_A) begin
         addr_sum = addr_sum - DEPTH_A;
      end
      wave_addr = addr_sum[AW-1:0];
   end

   // phase step with wrap at the period or at the memory depth
   always_comb begin
      phase_inc = CW'(cur_phase) + CW'(1);
      if ((phase_inc == CW'(entry.period)) || (phase_inc >= DEPTH_C)) begin
         next_phase = '0;
      end else begin
         next_phase = phase_inc[AW-1:0];
      end
   end

   // per-voice state update
   always_comb begin
      for (int v = 0; v < fvwm_pkg::ACTIVE_VOICES; v++) begin
         phase_in[v]     = phase_ff[v];
         last_note_in[v] = last_note_ff[v];
         if (step && (issue.voice == fvwm_pkg::VIDX_W'(v))) begin
            phase_in[v]     = next_phase;
            last_note_in[v] = issue.note;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < fvwm_pkg::ACTIVE_VOICES; v++) begin
            phase_ff[v]     <= '0;
            last_note_ff[v] <= '0;
         end
      end else begin
         for (int v = 0; v < fvwm_pkg::ACTIVE_VOICES; v++) begin
            phase_ff[v]     <= phase_in[v];
            last_note_ff[v] <= last_note_in[v];
         end
      end
   end

endmodule

/* hdl/four_voice_wavetable_mixer_core.sv */
// Four-voice wavetable mixer. Load the wave memory with wave-write items and the
// note table with note-write items, then send tick items; each tick returns one
// mixed_sample, the sum of one wave byte per voice. A write item is issued whole;
// a tick issues its voices one after another, since every voice needs its
// own read of the single-port wave memory. Items flow through a three-stage
// pipeline (note table read, voice phase update and wave read, accumulate), so
// the next item is taken while the last voices of a tick finish; after the tick's
// last voice is issued, its result passes the wave memory stage, the accumulate
// stage and the output register. Writes and reads keep item order, so a tick
// sees every write accepted before it. A result waiting on a stalled output
// holds the pipeline only when the next result is ready to replace it.
module four_voice_wavetable_mixer_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [fvwm_pkg::FUNC_W-1:0]    req_func,
   input  logic [fvwm_pkg::ADDR_W-1:0]    req_addr,
   input  logic [fvwm_pkg::BYTE_W-1:0]    req_wave_byte,
   input  logic [fvwm_pkg::OFFSET_W-1:0]  req_note_offset,
   input  logic [fvwm_pkg::PERIOD_W-1:0]  req_note_period,
   input  logic [fvwm_pkg::NOTE_W-1:0]    req_voice0_note,
   input  logic [fvwm_pkg::NOTE_W-1:0]    req_voice1_note,
   input  logic [fvwm_pkg::NOTE_W-1:0]    req_voice2_note,
   input  logic [fvwm_pkg::NOTE_W-1:0]    req_voice3_note,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [fvwm_pkg::SAMPLE_W-1:0]  rsp_mixed_sample
);

   localparam int unsigned VW = fvwm_pkg::VIDX_W;
   localparam logic [VW-1:0] LAST_VOICE = VW'(fvwm_pkg::ACTIVE_VOICES - 1);

   logic [fvwm_pkg::NOTE_W-1:0] req_note [fvwm_pkg::NOTE_FIELDS];

   // issue stage
   logic                          a_valid_ff, a_valid_in;
   logic [fvwm_pkg::FUNC_W-1:0]   a_func_ff, a_func_in;
   logic [fvwm_pkg::ADDR_W-1:0]   a_addr_ff, a_addr_in;
   logic [fvwm_pkg::BYTE_W-1:0]   a_byte_ff, a_byte_in;
   logic [fvwm_pkg::OFFSET_W-1:0] a_offset_ff, a_offset_in;
   logic [fvwm_pkg::PERIOD_W-1:0] a_period_ff, a_period_in;
   logic [fvwm_pkg::NOTE_W-1:0]   a_note_ff [fvwm_pkg::ACTIVE_VOICES];
   logic [fvwm_pkg::NOTE_W-1:0]   a_note_in [fvwm_pkg::ACTIVE_VOICES];
   logic [VW-1:0]                 a_voice_ff, a_voice_in;

   logic                          hold;
   logic                          a_is_tick;
   logic                          a_last_voice;
   logic                          a_done;
   logic                          req_take;
   logic [fvwm_pkg::NOTE_W-1:0]   cur_note;

   fvwm_pkg::issue_type           issue;
   logic                          tbl_wr_en;
   logic                          tbl_rd_en;
   logic [fvwm_pkg::NIDX_W-1:0]   tbl_addr;
   fvwm_pkg::note_entry_type      tbl_wr_data;
   fvwm_pkg::note_entry_type      tbl_rd_data;

   // wave memory stage
   fvwm_pkg::issue_type           b_ff, b_in;
   logic                          voice_step;
   logic                          wave_wr_en;
   logic [fvwm_pkg::WADDR_W-1:0]  voice_addr;
   logic [fvwm_pkg::WADDR_W-1:0]  wave_addr;
   logic [fvwm_pkg::BYTE_W-1:0]   wave_rd_data;

   // accumulate stage and output register
   logic                          c_valid_ff, c_valid_in;
   logic                          c_first_ff, c_first_in;
   logic                          c_last_ff, c_last_in;
   logic [fvwm_pkg::SAMPLE_W-1:0] acc_ff, acc_in;
   logic [fvwm_pkg::SAMPLE_W-1:0] total;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fvwm_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   assign req_note[0] = req_voice0_note;
   assign req_note[1] = req_voice1_note;
   assign req_note[2] = req_voice2_note;
   assign req_note[3] = req_voice3_note;

   // the pipeline stops only when a finished sum would overwrite a waiting result
   assign hold = c_valid_ff && c_last_ff && rsp_valid_ff && rsp_stall;

   assign a_is_tick    = a_func_ff == fvwm_pkg::FUNC_TICK;
   assign a_last_voice = a_voice_ff == LAST_VOICE;
   assign a_done       = a_valid_ff && !hold && (!a_is_tick || a_last_voice);
   assign req_stall    = a_valid_ff && !a_done;
   assign req_take     = req_valid && !req_stall;
   assign cur_note     = a_note_ff[a_voice_ff];

   // issue stage registers
   always_comb begin
      a_valid_in  = a_valid_ff;
      a_func_in   = a_func_ff;
      a_addr_in   = a_addr_ff;
      a_byte_in   = a_byte_ff;
      a_offset_in = a_offset_ff;
      a_period_in = a_period_ff;
      a_voice_in  = a_voice_ff;
      for (int v = 0; v < fvwm_pkg::ACTIVE_VOICES; v++) begin
         a_note_in[v] = a_note_ff[v];
      end
      if (req_take) begin
         a_valid_in  = 1'b1;
         a_func_in   = req_func;
         a_addr_in   = req_addr;
         a_byte_in   = req_wave_byte;
         a_offset_in = req_note_offset;
         a_period_in = req_note_period;
         a_voice_in  = '0;
         for (int v = 0; v < fvwm_pkg::ACTIVE_VOICES; v++) begin
            a_note_in[v] = req_note[v];
         end
      end else if (a_done) begin
         a_valid_in = 1'b0;
      end else if (a_valid_ff && !hold && a_is_tick) begin
         a_voice_in = a_voice_ff + VW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         a_voice_ff <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         a_voice_ff <= a_voice_in;
      end
      a_func_ff   <= a_func_in;
      a_addr_ff   <= a_addr_in;
      a_byte_ff   <= a_byte_in;
      a_offset_ff <= a_offset_in;
      a_period_ff <= a_period_in;
      for (int v = 0; v < fvwm_pkg::ACTIVE_VOICES; v++) begin
         a_note_ff[v] <= a_note_in[v];
      end
   end

   // dispatch: note table access here, wave memory work to the next stage
   always_comb begin
      issue              = '0;
      tbl_wr_en          = 1'b0;
      tbl_rd_en          = 1'b0;
      tbl_addr           = fvwm_pkg::note_index(cur_note);
      tbl_wr_data.offset = fvwm_pkg::wave_index(a_offset_ff);
      tbl_wr_data.period = a_period_ff;
      if (a_valid_ff && !hold) begin
         case (a_func_ff)
            fvwm_pkg::FUNC_WAVE_WR: begin
               issue.valid     = 1'b1;
               issue.op        = fvwm_pkg::OP_WAVE_WR;
               issue.wave_addr = fvwm_pkg::wave_index(a_addr_ff);
               issue.wave_byte = a_byte_ff;
            end
            fvwm_pkg::FUNC_NOTE_WR: begin
               if (a_addr_ff < fvwm_pkg::ADDR_W'(fvwm_pkg::NOTE_COUNT)) begin
                  tbl_wr_en = 1'b1;
                  tbl_addr  = a_addr_ff[fvwm_pkg::NIDX_W-1:0];
               end
            end
            fvwm_pkg::FUNC_TICK: begin
               tbl_rd_en   = 1'b1;
               issue.valid = 1'b1;
               issue.op    = fvwm_pkg::OP_VOICE;
               issue.voice = a_voice_ff;
               issue.note  = cur_note;
               issue.first = a_voice_ff == '0;
               issue.last  = a_last_voice;
            end
            default: begin
            end
         endcase
      end
   end

   fvwm_note_table u_note_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .rd_en   (tbl_rd_en),
      .addr    (tbl_addr),
      .wr_data (tbl_wr_data),
      .rd_data (tbl_rd_data)
   );

   // wave memory stage register
   assign b_in = hold ? b_ff : issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff <= '0;
      end else begin
         b_ff <= b_in;
      end
   end

   fvwm_voice_engine u_voice_engine (
      .clock     (clock),
      .reset     (reset),
      .advance   (!hold),
      .issue     (b_ff),
      .entry     (tbl_rd_data),
      .wave_addr (voice_addr)
   );

   // at most one wave memory access per cycle, write or voice read, none while held
   assign voice_step = !hold && b_ff.valid && (b_ff.op == fvwm_pkg::OP_VOICE);
   assign wave_wr_en = !hold && b_ff.valid && (b_ff.op == fvwm_pkg::OP_WAVE_WR);
   assign wave_addr  = wave_wr_en ? b_ff.wave_addr : voice_addr;

   fvwm_wave_ram u_wave_ram (
      .clock   (clock),
      .wr_en   (wave_wr_en),
      .rd_en   (voice_step),
      .addr    (wave_addr),
      .wr_data (b_ff.wave_byte),
      .rd_data (wave_rd_data)
   );

   // accumulate voices and load the output register
   assign total = (c_first_ff ? '0 : acc_ff) + fvwm_pkg::SAMPLE_W'(wave_rd_data);

   always_comb begin
      c_valid_in    = c_valid_ff;
      c_first_in    = c_first_ff;
      c_last_in     = c_last_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      if (!hold) begin
         c_valid_in = voice_step;
         c_first_in = b_ff.first;
         c_last_in  = b_ff.last;
         if (c_valid_ff) begin
            if (c_last_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = total;
            end else begin
               acc_in = total;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         c_valid_ff   <= c_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      c_first_ff    <= c_first_in;
      c_last_ff     <= c_last_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_sample_ff;

   // the single wave memory port never sees a read and a write together
   assert property (@(posedge clock) disable iff (reset) !(wave_wr_en && voice_step))
      else $error("wave memory read and write in one cycle");

   // a voice read issued to the wave memory reaches the accumulator next cycle
   assert property (@(posedge clock) disable iff (reset) voice_step |=> c_valid_ff)
      else $error("voice read lost before accumulation");

   // the tick voice counter stays within the active voices
   assert property (@(posedge clock) disable iff (reset) a_voice_ff <= LAST_VOICE)
      else $error("voice counter out of range");

   // a tick with voices left to issue keeps the input stalled
   assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && a_is_tick && !a_last_voice) |-> req_stall)
      else $error("input taken while a tick is still issuing");

   // while the pipeline is held the wave memory stays idle
   assert property (@(posedge clock) disable iff (reset) hold |-> !(wave_wr_en || voice_step))
      else $error("wave memory accessed while held");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int CLK_PERIOD        = 10;
   localparam int RESET_CYCLES      = 11;
   localparam int TOTAL_ITEMS       = 950;
   localparam int PERIOD_ZERO_TICKS = 24;
   localparam int LONG_HOLD         = 300;
   localparam int DRAIN_CYCLES      = 20;
   localparam int LIMIT_CYCLES      = 1000000;

   // sizes and field widths of the block
   localparam int WAVE_DEPTH    = fvwm_pkg::WAVE_DEPTH;
   localparam int NOTE_COUNT    = fvwm_pkg::NOTE_COUNT;
   localparam int NOTE_FIELDS   = fvwm_pkg::NOTE_FIELDS;
   localparam int ACTIVE_VOICES = fvwm_pkg::ACTIVE_VOICES;
   localparam int FUNC_W        = fvwm_pkg::FUNC_W;
   localparam int ADDR_W        = fvwm_pkg::ADDR_W;
   localparam int BYTE_W        = fvwm_pkg::BYTE_W;
   localparam int OFFSET_W      = fvwm_pkg::OFFSET_W;
   localparam int PERIOD_W      = fvwm_pkg::PERIOD_W;
   localparam int NOTE_W        = fvwm_pkg::NOTE_W;
   localparam int SAMPLE_W      = fvwm_pkg::SAMPLE_W;

   // spare function code that the block must ignore
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

   typedef struct {
      logic [FUNC_W-1:0]                  func;
      logic [ADDR_W-1:0]                  addr;
      logic [BYTE_W-1:0]                  wave_byte;
      logic [OFFSET_W-1:0]                note_offset;
      logic [PERIOD_W-1:0]                note_period;
      logic [NOTE_FIELDS-1:0][NOTE_W-1:0] notes;
      bit                                 drain_first;
   } mixer_cmd_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [FUNC_W-1:0]    req_func = '0;
   logic [ADDR_W-1:0]    req_addr = '0;
   logic [BYTE_W-1:0]    req_wave_byte = '0;
   logic [OFFSET_W-1:0]  req_note_offset = '0;
   logic [PERIOD_W-1:0]  req_note_period = '0;
   logic [NOTE_W-1:0]    req_voice0_note = '0;
   logic [NOTE_W-1:0]    req_voice1_note = '0;
   logic [NOTE_W-1:0]    req_voice2_note = '0;
   logic [NOTE_W-1:0]    req_voice3_note = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0]  rsp_mixed_sample;

   // stimulus queue and generator bookkeeping
   mixer_cmd_type cmd_queue[$];
   int            ready_notes[$];
   bit            note_loaded [NOTE_COUNT];
   int            gen_voice_note [NOTE_FIELDS] = '{default: 0};
   bit            drain_next = 1'b0;

   // generator copy of the block state, keeps every read on a written byte
   bit                  wave_known [WAVE_DEPTH];
   logic [OFFSET_W-1:0] gen_offset [NOTE_COUNT];
   logic [PERIOD_W-1:0] gen_period [NOTE_COUNT];
   int unsigned         gen_phase [NOTE_FIELDS] = '{default: 0};
   logic [NOTE_W-1:0]   gen_last [NOTE_FIELDS] = '{default: '0};

   // shadow state of the mixer
   logic [BYTE_W-1:0]   wave_shadow [WAVE_DEPTH];
   logic [OFFSET_W-1:0] note_base [NOTE_COUNT];
   logic [PERIOD_W-1:0] note_len [NOTE_COUNT];
   int unsigned         voice_pos [NOTE_FIELDS] = '{default: 0};
   logic [NOTE_W-1:0]   voice_note [NOTE_FIELDS] = '{default: '0};
   logic [SAMPLE_W-1:0] expected_samples[$];

   // handshake and run counters
   int cmds_sent = 0;
   int cmds_taken = 0;
   int samples_seen = 0;
   int mismatch_cnt = 0;
   int wave_writes_taken = 0;
   int note_writes_taken = 0;
   int ticks_taken = 0;
   int cycle_cnt = 0;

   // sender and receiver pacing
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   int next_hold_at = 100;
   int segment_left = 0;
   int stall_pct = 0;
   int stall_mix [4] = '{0, 20, 50, 85};

   four_voice_wavetable_mixer_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_addr         (req_addr),
      .req_wave_byte    (req_wave_byte),
      .req_note_offset  (req_note_offset),
      .req_note_period  (req_note_period),
      .req_voice0_note  (req_voice0_note),
      .req_voice1_note  (req_voice1_note),
      .req_voice2_note  (req_voice2_note),
      .req_voice3_note  (req_voice3_note),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mixed_sample (rsp_mixed_sample)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // item with every payload field random, function given
   function automatic mixer_cmd_type blank_cmd(logic [FUNC_W-1:0] f);
      mixer_cmd_type c;
      c.func = f;
      c.addr = ADDR_W'($urandom);
      c.wave_byte = BYTE_W'($urandom);
      c.note_offset = OFFSET_W'($urandom);
      c.note_period = PERIOD_W'($urandom);
      for (int v = 0; v < NOTE_FIELDS; v++) c.notes[v] = NOTE_W'($urandom);
      c.drain_first = 1'b0;
      return c;
   endfunction

   function automatic void queue_cmd(mixer_cmd_type c);
      c.drain_first = drain_next;
      drain_next = 1'b0;
      cmd_queue.push_back(c);
   endfunction

   function automatic void wave_write(int a, int b);
      mixer_cmd_type c;
      c = blank_cmd(fvwm_pkg::FUNC_WAVE_WR);
      c.addr = ADDR_W'(a);
      c.wave_byte = BYTE_W'(b);
      wave_known[int'(c.addr) % WAVE_DEPTH] = 1'b1;
      queue_cmd(c);
   endfunction

   // out-of-range note indexes are left out of the playable set
   function automatic void note_write(int n, int o, int p);
      mixer_cmd_type c;
      c = blank_cmd(fvwm_pkg::FUNC_NOTE_WR);
      c.addr = ADDR_W'(n);
      c.note_offset = OFFSET_W'(o);
      c.note_period = PERIOD_W'(p);
      queue_cmd(c);
      if (n < NOTE_COUNT) begin
         gen_offset[n] = c.note_offset;
         gen_period[n] = c.note_period;
         if (!note_loaded[n]) begin
            note_loaded[n] = 1'b1;
            ready_notes.push_back(n);
         end
      end
   endfunction

   function automatic void tick_notes(int n0, int n1, int n2, int n3);
      mixer_cmd_type c;
      int idx;
      int a;
      c = blank_cmd(fvwm_pkg::FUNC_TICK);
      c.notes[0] = NOTE_W'(n0);
      c.notes[1] = NOTE_W'(n1);
      c.notes[2] = NOTE_W'(n2);
      c.notes[3] = NOTE_W'(n3);
      for (int v = 0; v < NOTE_FIELDS; v++) gen_voice_note[v] = int'(c.notes[v]);
      // step the generator copy and write any byte the tick is about to read
      for (int v = 0; v < ACTIVE_VOICES; v++) begin
         idx = int'(c.notes[v]) % NOTE_COUNT;
         if (gen_last[v] != c.notes[v]) begin
            gen_last[v] = c.notes[v];
            gen_phase[v] = 0;
         end
         a = (int'(gen_offset[idx]) + int'(gen_phase[v])) % WAVE_DEPTH;
         if (!wave_known[a]) wave_write(a, $urandom);
         gen_phase[v]++;
         if (gen_phase[v] == gen_period[idx] || gen_phase[v] >= WAVE_DEPTH)
            gen_phase[v] = 0;
      end
      queue_cmd(c);
   endfunction

   // voices mostly keep their note so phases get to advance
   function automatic void tick_wander(bit pin_voice0);
      for (int v = 0; v < NOTE_FIELDS; v++) begin
         if (!(pin_voice0 && v == 0) && $urandom_range(0, 3) == 0)
            gen_voice_note[v] = ready_notes[$urandom_range(0, ready_notes.size() - 1)];
      end
      tick_notes(gen_voice_note[0], gen_voice_note[1], gen_voice_note[2], gen_voice_note[3]);
   endfunction

   function automatic int random_period();
      int p;
      case ($urandom_range(0, 9))
         0: p = 0;
         1, 2: p = int'(PERIOD_W'($urandom));
         default: p = $urandom_range(1, 16);
      endcase
      return p;
   endfunction

   // items the block must take without effect, plus stray wave writes
   function automatic void odd_cmd();
      case ($urandom_range(0, 2))
         0: queue_cmd(blank_cmd(FUNC_SPARE));
         1: note_write($urandom_range(NOTE_COUNT, (1 << ADDR_W) - 1), $urandom, $urandom);
         default: wave_write($urandom_range(0, WAVE_DEPTH - 1), $urandom);
      endcase
   endfunction

   // shadow update for one accepted item; ticks add one expected sample
   function automatic void play_and_predict(mixer_cmd_type c);
      int unsigned sum;
      int idx;
      case (c.func)
         fvwm_pkg::FUNC_WAVE_WR: wave_shadow[int'(c.addr) % WAVE_DEPTH] = c.wave_byte;
         fvwm_pkg::FUNC_NOTE_WR: begin
            if (c.addr < NOTE_COUNT) begin
               note_base[c.addr] = c.note_offset;
               note_len[c.addr] = c.note_period;
            end
         end
         fvwm_pkg::FUNC_TICK: begin
            sum = 0;
            for (int v = 0; v < ACTIVE_VOICES; v++) begin
               idx = int'(c.notes[v]) % NOTE_COUNT;
               // a new note restarts the voice at the head of its waveform
               if (voice_note[v] != c.notes[v]) begin
                  voice_note[v] = c.notes[v];
                  voice_pos[v] = 0;
               end
               sum += wave_shadow[(int'(note_base[idx]) + voice_pos[v]) % WAVE_DEPTH];
               voice_pos[v]++;
               if (voice_pos[v] == note_len[idx] || voice_pos[v] >= WAVE_DEPTH)
                  voice_pos[v] = 0;
            end
            expected_samples.push_back(SAMPLE_W'(sum));
         end
         default: ;
      endcase
   endfunction

   // request driver: bursts with random gaps, holds payload until taken
   always @(negedge clock) begin : drive_req
      mixer_cmd_type next_cmd;
      bit            launch;
      launch = 1'b0;
      if (!reset && cmds_sent == cmds_taken) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (cmd_queue.size() > 0 &&
                      (!cmd_queue[0].drain_first || expected_samples.size() == 0)) begin
            next_cmd = cmd_queue.pop_front();
            launch = 1'b1;
            cmds_sent++;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
      if (launch) begin
         req_valid <= 1'b1;
         req_func <= next_cmd.func;
         req_addr <= next_cmd.addr;
         req_wave_byte <= next_cmd.wave_byte;
         req_note_offset <= next_cmd.note_offset;
         req_note_period <= next_cmd.note_period;
         req_voice0_note <= next_cmd.notes[0];
         req_voice1_note <= next_cmd.notes[1];
         req_voice2_note <= next_cmd.notes[2];
         req_voice3_note <= next_cmd.notes[3];
      end else if (cmds_sent == cmds_taken) begin
         req_valid <= 1'b0;
      end
   end

   // result stall: random segments of varying density plus long hold-offs
   always @(negedge clock) begin : drive_stall
      bit stall_now;
      if (hold_left > 0) begin
         hold_left--;
         stall_now = 1'b1;
      end else if (samples_seen >= next_hold_at) begin
         hold_left = LONG_HOLD;
         next_hold_at += 2500;
         stall_now = 1'b1;
      end else begin
         if (segment_left == 0) begin
            segment_left = $urandom_range(20, 200);
            stall_pct = stall_mix[$urandom_range(0, 3)];
         end
         segment_left--;
         stall_now = ($urandom_range(0, 99) < stall_pct);
      end
      rsp_stall <= stall_now;
   end

   // accepted items feed the shadow model, accepted samples are checked
   always @(posedge clock) begin : watch
      mixer_cmd_type seen;
      logic [SAMPLE_W-1:0] want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen.func = req_func;
            seen.addr = req_addr;
            seen.wave_byte = req_wave_byte;
            seen.note_offset = req_note_offset;
            seen.note_period = req_note_period;
            seen.notes[0] = req_voice0_note;
            seen.notes[1] = req_voice1_note;
            seen.notes[2] = req_voice2_note;
            seen.notes[3] = req_voice3_note;
            seen.drain_first = 1'b0;
            cmds_taken++;
            if (req_func == fvwm_pkg::FUNC_WAVE_WR) wave_writes_taken++;
            if (req_func == fvwm_pkg::FUNC_NOTE_WR) note_writes_taken++;
            if (req_func == fvwm_pkg::FUNC_TICK) ticks_taken++;
            play_and_predict(seen);
         end
         if (rsp_valid && !rsp_stall) begin
            samples_seen++;
            if (expected_samples.size() == 0) begin
               mismatch_cnt++;
               $display("%0t: unexpected mixed_sample, expected none, actual %0d",
                        $time, rsp_mixed_sample);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_mixed_sample !== want) begin
                  mismatch_cnt++;
                  $display("%0t: mixed_sample mismatch, expected %0d, actual %0d",
                           $time, want, rsp_mixed_sample);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d samples still owed",
                  cycle_cnt, expected_samples.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      int pick;
      int n;
      int o;
      int p;
      int start_at;

      // directed: field extremes, address wrap, ignored items
      note_write(0, 0, 0);
      note_write(NOTE_COUNT - 1, WAVE_DEPTH - 1, (1 << PERIOD_W) - 1);
      note_write(NOTE_COUNT, 7, 7);
      note_write((1 << ADDR_W) - 1, (1 << OFFSET_W) - 1, (1 << PERIOD_W) - 1);
      queue_cmd(blank_cmd(FUNC_SPARE));
      wave_write(WAVE_DEPTH - 1, 255);
      wave_write(0, 255);
      wave_write(100, 0);
      note_write(1, 100, 1);
      note_write(2, 200, 3);
      // full-scale sum, then the read address wraps past the top of memory
      tick_notes(NOTE_COUNT - 1, NOTE_COUNT - 1, NOTE_COUNT - 1, NOTE_COUNT - 1);
      tick_notes(NOTE_COUNT - 1, NOTE_COUNT - 1, NOTE_COUNT - 1, NOTE_COUNT - 1);
      // zero sum, period of one keeps the voice on one byte
      tick_notes(1, 1, 1, 1);
      tick_notes(1, 1, 1, 1);
      tick_notes(0, 1, 2, NOTE_COUNT - 1);
      tick_notes(2, 2, 2, 2);
      tick_notes(2, 2, 2, 2);
      // shrink the period under the live phase: phase keeps stepping
      note_write(2, 200, 1);
      tick_notes(2, 2, 2, 2);
      tick_notes(2, 2, 2, 2);
      tick_notes(2, 2, 2, 2);

      // period-zero note near the top of memory: phase runs on, address wraps
      drain_next = 1'b1;
      note_write(5, WAVE_DEPTH - 6, 0);
      tick_notes(5, gen_voice_note[1], gen_voice_note[2], gen_voice_note[3]);
      repeat (PERIOD_ZERO_TICKS) tick_wander(1'b1);

      // random phrases: load notes, play them, some noise and drains
      drain_next = 1'b1;
      while (cmd_queue.size() < TOTAL_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            n = $urandom_range(0, NOTE_COUNT - 1);
            o = $urandom_range(0, WAVE_DEPTH - 1);
            p = random_period();
            start_at = o;
            repeat ($urandom_range(1, 8)) begin
               wave_write(o, $urandom);
               o = (o + 1) % WAVE_DEPTH;
            end
            note_write(n, start_at, p);
         end else if (pick < 20) begin
            odd_cmd();
         end else if (pick < 24) begin
            note_write(gen_voice_note[$urandom_range(0, NOTE_FIELDS - 1)], $urandom,
                       $urandom_range(1, 3));
         end else if (pick < 26) begin
            drain_next = 1'b1;
         end else begin
            repeat ($urandom_range(2, 16)) tick_wander(1'b0);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() != 0 || cmds_sent != cmds_taken || expected_samples.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("accepted %0d items: %0d wave writes, %0d note writes, %0d ticks",
               cmds_taken, wave_writes_taken, note_writes_taken, ticks_taken);
      $display("checked %0d mixed samples in %0d cycles, %0d errors",
               samples_seen, cycle_cnt, mismatch_cnt);
      if (mismatch_cnt == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
